// ===== hw/rtl/icaf_pkg.sv =====
// imu attitude filter package: payload types, cordic table and constants
// no dependencies
`default_nettype none
package icaf_pkg;
  localparam int TableLen = 30;
  localparam int CordicStepsDefault = 16;
  localparam logic [15:0] GammaReset = 16'd64881;
  localparam logic [15:0] PeriodReset = 16'd655;
  localparam logic signed [35:0] Deg180Q24 = 36'sd3019898880;
  localparam logic [31:0] InvGainQ32 = 32'd2608131496;
  localparam logic [0:0] RegGamma = 1'b0;
  localparam logic [0:0] RegPeriod = 1'b1;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [23:0] rate_x;
    logic signed [23:0] rate_y;
    logic signed [23:0] rate_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] roll_deg;
    logic signed [31:0] pitch_deg;
    logic signed [31:0] yaw_deg;
  } out_item_t;

  function automatic logic [29:0] atan_q24(input logic [4:0] i);
    case (i)
      5'd0: atan_q24 = 30'd754974720;
      5'd1: atan_q24 = 30'd445687602;
      5'd2: atan_q24 = 30'd235489088;
      5'd3: atan_q24 = 30'd119537938;
      5'd4: atan_q24 = 30'd60000934;
      5'd5: atan_q24 = 30'd30029717;
      5'd6: atan_q24 = 30'd15018523;
      5'd7: atan_q24 = 30'd7509720;
      5'd8: atan_q24 = 30'd3754917;
      5'd9: atan_q24 = 30'd1877466;
      5'd10: atan_q24 = 30'd938734;
      5'd11: atan_q24 = 30'd469367;
      5'd12: atan_q24 = 30'd234684;
      5'd13: atan_q24 = 30'd117342;
      5'd14: atan_q24 = 30'd58671;
      5'd15: atan_q24 = 30'd29335;
      5'd16: atan_q24 = 30'd14668;
      5'd17: atan_q24 = 30'd7334;
      5'd18: atan_q24 = 30'd3667;
      5'd19: atan_q24 = 30'd1833;
      5'd20: atan_q24 = 30'd917;
      5'd21: atan_q24 = 30'd458;
      5'd22: atan_q24 = 30'd229;
      5'd23: atan_q24 = 30'd115;
      5'd24: atan_q24 = 30'd57;
      5'd25: atan_q24 = 30'd29;
      5'd26: atan_q24 = 30'd14;
      5'd27: atan_q24 = 30'd7;
      5'd28: atan_q24 = 30'd4;
      5'd29: atan_q24 = 30'd2;
      default: atan_q24 = 30'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/imu_complementary_attitude_filter.sv =====
// imu complementary attitude filter: cordic roll/pitch and per-axis blend
// depends on icaf_pkg
// from input accept to out_valid: a cordic pass of S steps (S = CORDIC_STEPS capped at 30),
// the magnitude multiply, a second cordic pass, then per axis rate*dt and the two blend products,
// all multiplies 2 bits per cycle
// one item at a time: in_stall holds until the result is taken with out_stall low
// synchronous reset clears estimates, registers to defaults and the control state
`default_nettype none
module imu_complementary_attitude_filter #(
  parameter int CORDIC_STEPS = icaf_pkg::CordicStepsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire icaf_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output icaf_pkg::out_item_t out_data,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [15:0] cfg_data
);
  import icaf_pkg::*;

  localparam int Steps = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;
  localparam logic [4:0] LastStep = 5'(Steps - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CORD = 3'd1;
  localparam logic [2:0] S_MAG = 3'd2;
  localparam logic [2:0] S_SUM = 3'd3;
  localparam logic [2:0] S_BLD = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state;
  logic [15:0] gamma, period;
  logic signed [31:0] est [3];
  in_item_t item;

  logic signed [35:0] cx, cy, cz;
  logic [4:0] step;
  logic second;
  logic signed [35:0] roll_ang, pitch_ang;
  logic [5:0] cnt;
  logic [1:0] axis;

  // serial shift-add multiplier, 2 bits per cycle
  logic [63:0] macc;
  logic [31:0] mplier;
  logic [63:0] mcand;
  logic signed [63:0] sum;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= GammaReset;
      period <= PeriodReset;
    end else if (cfg_valid) begin
      if (cfg_index == RegGamma) gamma <= cfg_data;
      else period <= cfg_data;
    end
  end

  logic signed [35:0] dx, dy;
  assign dx = cy >>> step;
  assign dy = cx >>> step;

  function automatic logic signed [31:0] sat(input logic signed [63:0] t);
    logic signed [63:0] r;
    r = (t + 64'sd8388608) >>> 24;
    if (r > 64'sd2147483647) sat = 32'h7fffffff;
    else if (r < -64'sd2147483648) sat = 32'h80000000;
    else sat = r[31:0];
  endfunction

  logic signed [35:0] acc_sel;
  logic signed [23:0] rate_sel;
  always_comb begin
    case (axis)
      2'd0: begin acc_sel = roll_ang; rate_sel = item.rate_x; end
      2'd1: begin acc_sel = pitch_ang; rate_sel = item.rate_y; end
      default: begin acc_sel = '0; rate_sel = item.rate_z; end
    endcase
  end

  logic [63:0] pp;
  assign pp = (mplier[0] ? mcand : 64'd0) + (mplier[1] ? (mcand << 1) : 64'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      est[0] <= '0; est[1] <= '0; est[2] <= '0;
      step <= '0; second <= 1'b0; cnt <= '0; axis <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          item <= in_data;
          second <= 1'b0;
          step <= '0;
          if (in_data.accel_z < 0) begin
            cx <= -(36'(in_data.accel_z) <<< 14);
            cy <= -(36'(in_data.accel_y) <<< 14);
            cz <= (in_data.accel_y >= 0) ? Deg180Q24 : -Deg180Q24;
          end else begin
            cx <= 36'(in_data.accel_z) <<< 14;
            cy <= 36'(in_data.accel_y) <<< 14;
            cz <= '0;
          end
          state <= S_CORD;
        end
        S_CORD: begin
          if (cy > 0) begin
            cx <= cx + dx; cy <= cy - dy; cz <= cz + 36'(atan_q24(step));
          end else begin
            cx <= cx - dx; cy <= cy + dy; cz <= cz - 36'(atan_q24(step));
          end
          step <= step + 5'd1;
          if (step == LastStep) state <= S_MAG;
        end
        S_MAG: begin
          if (!second) begin
            if (cnt == 6'd0) begin
              roll_ang <= (item.accel_y == 0 && item.accel_z == 0) ? '0 : cz;
              macc <= '0;
              mplier <= InvGainQ32;
              mcand <= (item.accel_y == 0 && item.accel_z == 0) ? '0 : 64'(cx);
              cnt <= 6'd1;
            end else if (cnt <= 6'd16) begin
              macc <= macc + pp;
              mcand <= mcand << 2;
              mplier <= mplier >> 2;
              cnt <= cnt + 6'd1;
            end else begin
              cnt <= '0;
              second <= 1'b1;
              step <= '0;
              cx <= 36'(macc[63:32]);
              cy <= -(36'(item.accel_x) <<< 14);
              cz <= '0;
              state <= S_CORD;
            end
          end else begin
            pitch_ang <= (item.accel_x == 0 && cx == 0) ? '0 : cz;
            axis <= '0;
            cnt <= '0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          // rate*dt serially
          if (cnt == 6'd0) begin
            macc <= '0;
            mcand <= 64'(rate_sel);
            mplier <= {16'd0, period};
            cnt <= 6'd1;
          end else if (cnt <= 6'd8) begin
            macc <= macc + pp;
            mcand <= mcand << 2;
            mplier <= mplier >> 2;
            cnt <= cnt + 6'd1;
          end else begin
            sum <= (64'(est[axis]) <<< 8) + $signed(macc);
            cnt <= '0;
            state <= S_BLD;
          end
        end
        S_BLD: begin
          // (1 - gamma)*acc then gamma*sum into one accumulator
          if (cnt == 6'd0) begin
            macc <= '0;
            mcand <= 64'(acc_sel);
            mplier <= {15'd0, 17'(17'd65536 - {1'b0, gamma})};
            cnt <= 6'd1;
          end else if (cnt <= 6'd9 || (cnt >= 6'd11 && cnt <= 6'd18)) begin
            macc <= macc + pp;
            mcand <= mcand << 2;
            mplier <= mplier >> 2;
            cnt <= cnt + 6'd1;
          end else if (cnt == 6'd10) begin
            mcand <= sum;
            mplier <= {16'd0, gamma};
            cnt <= 6'd11;
          end else begin
            est[axis] <= sat($signed(macc));
            cnt <= '0;
            if (axis == 2'd2) state <= S_OUT;
            else begin
              axis <= axis + 2'd1;
              state <= S_SUM;
            end
          end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_data.roll_deg = est[0];
  assign out_data.pitch_deg = est[1];
  assign out_data.yaw_deg = est[2];

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result changed under stall");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CORD) |-> (step <= LastStep)) else $error("cordic step overrun");
endmodule
`default_nettype wire
